[rtl/core/pds_pkg.sv]
// Package for the proper divisor sum block.
// Holds field widths and stream packing constants; no dependencies.
`default_nettype none

package pds_pkg;

  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned CNT_W      = 11;
  localparam int unsigned SUM_W      = 36;
  localparam int unsigned OUT_BITS   = CNT_W + SUM_W + 2;
  localparam int unsigned OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [SUM_W-1:0] sum_t;

endpackage

`default_nettype wire

[rtl/core/proper_divisor_sum.sv]
// Top level of the proper divisor sum block: aliquot sum, perfect and amicable test.
// Depends on pds_pkg and the iterative divider pds_div.
`default_nettype none

// Each item on the input stream is an integer n (its low NUM_BITS bits); each result
// carries the proper divisor count, the aliquot sum s, a perfect flag (s == n, n != 0)
// and an amicable flag (s < n and the aliquot sum of s equals n). Trial divisors d run
// from 1 while d*d <= value, through one shared restoring divider; an item takes one
// pass on n plus, when s < n, a second pass on s. The block accepts one item at a time;
// the result sits in an output register while the next item is taken.
module proper_divisor_sum
  import pds_pkg::*;
#(
  parameter int unsigned NUM_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // [31:0] number_in
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic      [OUT_DATA_W-1:0] out_tdata   // [10:0] divisor_count, [46:11] divisor_sum,
                                                 // [47] perfect_flag, [48] amicable_flag, zeros
);

  localparam int unsigned NB  = NUM_BITS;
  localparam int unsigned DW  = (NB + 1) / 2 + 1;
  localparam int unsigned SQW = 2 * DW;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TEST,
    ST_DIV,
    ST_CHK_D,
    ST_CHK_Q,
    ST_END,
    ST_OUT
  } state_t;

  state_t           state_r;
  logic             pass_r;
  logic [NB-1:0]    n_r;
  logic [NB-1:0]    v_r;
  logic [DW-1:0]    d_r;
  logic [SQW-1:0]   dsq_r;
  cnt_t             cnt_r;
  sum_t             sum_r;
  cnt_t             res_cnt_r;
  sum_t             res_sum_r;
  logic             perfect_r;
  logic             div_start_r;
  logic             out_tvalid_r;
  cnt_t             out_cnt_r;
  sum_t             out_sum_r;
  logic             out_perfect_r;
  logic             out_amicable_r;

  logic             div_done;
  logic [NB-1:0]    div_quot;
  logic [DW-1:0]    div_rem;
  logic [NB-1:0]    d_ext;
  sum_t             n_ext;
  logic             out_free;

  assign d_ext    = {{(NB-DW){1'b0}}, d_r};
  assign n_ext    = {{(SUM_W-NB){1'b0}}, n_r};
  assign out_free = !out_tvalid_r || out_tready;

  pds_div #(
    .DVD_W (NB),
    .DVS_W (DW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start_r),
    .dividend  (v_r),
    .divisor   (d_r),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      div_start_r  <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      div_start_r <= (state_r == ST_TEST) && (dsq_r <= {{(SQW-NB){1'b0}}, v_r});
      if (out_tvalid_r && out_tready && (state_r != ST_OUT)) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            n_r     <= in_tdata[NB-1:0];
            v_r     <= in_tdata[NB-1:0];
            pass_r  <= 1'b0;
            d_r     <= DW'(1);
            dsq_r   <= SQW'(1);
            cnt_r   <= '0;
            sum_r   <= '0;
            state_r <= ST_TEST;
          end
        end
        ST_TEST: begin
          if (dsq_r <= {{(SQW-NB){1'b0}}, v_r}) begin
            state_r <= ST_DIV;
          end else begin
            state_r <= ST_END;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state_r <= ST_CHK_D;
          end
        end
        ST_CHK_D: begin
          if (div_rem == '0 && d_ext < v_r) begin
            cnt_r <= cnt_r + 1'b1;
            sum_r <= sum_r + {{(SUM_W-DW){1'b0}}, d_r};
          end
          state_r <= ST_CHK_Q;
        end
        ST_CHK_Q: begin
          if (div_rem == '0 && div_quot != d_ext && div_quot < v_r) begin
            cnt_r <= cnt_r + 1'b1;
            sum_r <= sum_r + {{(SUM_W-NB){1'b0}}, div_quot};
          end
          d_r     <= d_r + 1'b1;
          dsq_r   <= dsq_r + {{(SQW-DW-1){1'b0}}, d_r, 1'b1};
          state_r <= ST_TEST;
        end
        ST_END: begin
          if (!pass_r) begin
            res_cnt_r <= cnt_r;
            res_sum_r <= sum_r;
            perfect_r <= (n_r != '0) && (sum_r == n_ext);
            if (sum_r < n_ext) begin
              v_r     <= sum_r[NB-1:0];
              pass_r  <= 1'b1;
              d_r     <= DW'(1);
              dsq_r   <= SQW'(1);
              cnt_r   <= '0;
              sum_r   <= '0;
              state_r <= ST_TEST;
            end else begin
              sum_r   <= '0;
              state_r <= ST_OUT;
            end
          end else begin
            state_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_cnt_r      <= res_cnt_r;
            out_sum_r      <= res_sum_r;
            out_perfect_r  <= perfect_r;
            out_amicable_r <= pass_r && (sum_r == n_ext);
            out_tvalid_r   <= 1'b1;
            state_r        <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(OUT_DATA_W-OUT_BITS){1'b0}}, out_amicable_r, out_perfect_r,
                       out_sum_r, out_cnt_r};

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> !(out_perfect_r && out_amicable_r))
    else $error("perfect and amicable flags both set");

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV))
    else $error("divider finished outside the divide wait");

  a_start_to_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_start_r |-> (state_r == ST_DIV) && (d_r != '0))
    else $error("divider started without a valid trial divisor");

  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == ST_TEST) && !pass_r)
    else $error("accepted item did not start the first pass");

endmodule

`default_nettype wire

[rtl/core/pds_div.sv]
// Restoring divider, one quotient bit per cycle.
// Shared by every trial division of the proper divisor sum block; no package needed.
`default_nettype none

module pds_div #(
  parameter int unsigned DVD_W = 32,
  parameter int unsigned DVS_W = 17
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic                  done,
  output logic      [DVD_W-1:0] quotient,
  output logic      [DVS_W-1:0] remainder
);

  localparam int unsigned STEP_W = $clog2(DVD_W + 1);

  logic [STEP_W-1:0] step_r;
  logic              done_r;
  logic [DVD_W-1:0]  quot_r;
  logic [DVS_W-1:0]  rem_r;
  logic [DVS_W-1:0]  dvs_r;
  logic [DVS_W:0]    rem_sh;
  logic              fits;

  assign rem_sh = {rem_r, quot_r[DVD_W-1]};
  assign fits   = rem_sh >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= !start && (step_r == STEP_W'(1));
      if (start) begin
        step_r <= STEP_W'(DVD_W);
        quot_r <= dividend;
        rem_r  <= '0;
        dvs_r  <= divisor;
      end else if (step_r != '0) begin
        step_r <= step_r - 1'b1;
        quot_r <= {quot_r[DVD_W-2:0], fits};
        if (fits) begin
          rem_r <= DVS_W'(rem_sh - {1'b0, dvs_r});
        end else begin
          rem_r <= rem_sh[DVS_W-1:0];
        end
      end
    end
  end

  assign done      = done_r;
  assign quotient  = quot_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire
